/* hdl/tppa_pkg.sv */
`timescale 1ns / 1ps

package tppa_pkg;

  // Sample and accumulator widths
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned RAW_SUM_W   = 29;
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned PROD_W      = 2 * SAMPLE_BITS;

  // Channel and sum counts
  localparam int unsigned N_CHAN   = 6;
  localparam int unsigned N_PHASE  = 3;
  localparam int unsigned NUM_SUMS = 15;
  localparam int unsigned QTY_W    = 4;
  localparam int unsigned ADDR_W   = $clog2(NUM_SUMS);
  localparam int unsigned CFG_IDX_W = 3;

  // Quantity map: raw sums, then square sums, then power sums
  localparam logic [QTY_W-1:0] Q_SQ_BASE  = QTY_W'(N_CHAN);
  localparam logic [QTY_W-1:0] Q_PWR_BASE = QTY_W'(2 * N_CHAN);
  localparam logic [QTY_W-1:0] Q_LAST     = QTY_W'(NUM_SUMS - 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_V1 = 3'd0,
    REG_OFFSET_V2 = 3'd1,
    REG_OFFSET_V3 = 3'd2,
    REG_OFFSET_I1 = 3'd3,
    REG_OFFSET_I2 = 3'd4,
    REG_OFFSET_I3 = 3'd5
  } cfg_reg_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  typedef struct packed {
    sample_t sample_v1;
    sample_t sample_v2;
    sample_t sample_v3;
    sample_t sample_i1;
    sample_t sample_i2;
    sample_t sample_i3;
    logic    end_window;
  } in_req_t;

  typedef struct packed {
    logic [QTY_W-1:0] quantity;
    sum_t             total;
    logic             last_of_run;
  } out_res_t;

  // Subtract the offset and clamp to the signed sample range
  function automatic sample_t sat_corr(sample_t raw, sample_t off);
    logic signed [SAMPLE_BITS:0] diff;
    sample_t                     res;
    diff = (SAMPLE_BITS + 1)'(raw) - (SAMPLE_BITS + 1)'(off);
    if (diff[SAMPLE_BITS] != diff[SAMPLE_BITS-1]) begin
      res = {diff[SAMPLE_BITS], {(SAMPLE_BITS - 1){~diff[SAMPLE_BITS]}}};
    end else begin
      res = diff[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

endpackage

/* hdl/tppa_sum_ram.sv */
`timescale 1ns / 1ps

// Sum storage: one read and one write port, registered read data.
// Entries never written since reset read as zero.
module tppa_sum_ram (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [tppa_pkg::ADDR_W-1:0] rd_addr_i,
  output tppa_pkg::sum_t             rd_data_o,
  input  logic                       wr_en_i,
  input  logic [tppa_pkg::ADDR_W-1:0] wr_addr_i,
  input  tppa_pkg::sum_t             wr_data_i
);

  tppa_pkg::sum_t                  mem [tppa_pkg::NUM_SUMS];
  logic [tppa_pkg::NUM_SUMS-1:0]   written_q;
  tppa_pkg::sum_t                  rd_data_q;
  logic                            rd_written_q;

  // Track which entries hold a written value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

/* hdl/three_phase_power_accumulator.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                  | Payload
// ---------+-----+----------------------------+--------------------------------
// input    | in  | in_valid_i / in_ready_o    | in_req_i  (six samples, end flag)
// result   | out | out_valid_o / out_ready_i  | out_res_o (quantity, total, last)
// config   | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Each sample set visits the fifteen sums, kept in one memory with one read
// and one write port; one sum is read, updated and written back per cycle
// unless stalled. A one-entry input buffer takes the next set while one is
// in work. On a window end the updated sums leave one per cycle; a stalled
// result holds the sum pipeline. Reset clears per-entry written flags, no sweep.
module three_phase_power_accumulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tppa_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tppa_pkg::out_res_t            out_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tppa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tppa_pkg::SAMPLE_BITS-1:0] cfg_data_i
);

  tppa_pkg::sample_t  off_q [tppa_pkg::N_CHAN];

  tppa_pkg::in_req_t  buf_q;
  logic               buf_vld_q;

  logic               work_vld_q;
  logic [tppa_pkg::QTY_W-1:0] step_q;
  tppa_pkg::sample_t  raw_q  [tppa_pkg::N_CHAN];
  tppa_pkg::sample_t  corr_q [tppa_pkg::N_CHAN];
  logic               end_q;

  logic               b_vld_q;
  logic [tppa_pkg::QTY_W-1:0] b_idx_q;
  logic               b_end_q;
  tppa_pkg::sum_t     term_q;

  logic               out_vld_q;
  tppa_pkg::out_res_t out_q;

  logic               stall;
  logic               a_fire;
  logic               a_done;
  logic               load;
  logic               in_fire;
  logic               b_fire;
  logic               emit;
  tppa_pkg::sample_t  mul_b;
  logic signed [tppa_pkg::PROD_W-1:0] prod;
  tppa_pkg::sum_t     term_d;
  tppa_pkg::sum_t     rd_data;
  tppa_pkg::sum_t     sum_full;
  logic signed [tppa_pkg::RAW_SUM_W-1:0] raw_sum;
  tppa_pkg::sum_t     sum_new;

  // Handshake and pipeline control
  always_comb begin
    stall   = b_vld_q && b_end_q && out_vld_q && !out_ready_i;
    a_fire  = work_vld_q && !stall;
    a_done  = a_fire && (step_q == tppa_pkg::Q_LAST);
    load    = buf_vld_q && (!work_vld_q || a_done);
    b_fire  = b_vld_q && !stall;
    emit    = b_fire && b_end_q;
  end

  assign in_ready_o  = !buf_vld_q || load;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Offset registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < tppa_pkg::N_CHAN; k++) begin
        off_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tppa_pkg::REG_OFFSET_V1: off_q[0] <= cfg_data_i;
        tppa_pkg::REG_OFFSET_V2: off_q[1] <= cfg_data_i;
        tppa_pkg::REG_OFFSET_V3: off_q[2] <= cfg_data_i;
        tppa_pkg::REG_OFFSET_I1: off_q[3] <= cfg_data_i;
        tppa_pkg::REG_OFFSET_I2: off_q[4] <= cfg_data_i;
        tppa_pkg::REG_OFFSET_I3: off_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state: buffer, sequencer, sum stage, output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_vld_q  <= 1'b0;
      work_vld_q <= 1'b0;
      step_q     <= '0;
      b_vld_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        buf_vld_q <= 1'b1;
      end else if (load) begin
        buf_vld_q <= 1'b0;
      end
      if (load) begin
        work_vld_q <= 1'b1;
        step_q     <= '0;
      end else if (a_done) begin
        work_vld_q <= 1'b0;
      end else if (a_fire) begin
        step_q <= step_q + 1'b1;
      end
      if (!stall) begin
        b_vld_q <= a_fire;
      end
      out_vld_q <= emit || (out_vld_q && !out_ready_i);
    end
  end

  // Hold the incoming request
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      buf_q <= in_req_i;
    end
  end

  // Load a sample set, then rotate so each step reads fixed taps
  always_ff @(posedge clk_i) begin
    if (load) begin
      raw_q[0]  <= buf_q.sample_v1;
      raw_q[1]  <= buf_q.sample_v2;
      raw_q[2]  <= buf_q.sample_v3;
      raw_q[3]  <= buf_q.sample_i1;
      raw_q[4]  <= buf_q.sample_i2;
      raw_q[5]  <= buf_q.sample_i3;
      corr_q[0] <= tppa_pkg::sat_corr(buf_q.sample_v1, off_q[0]);
      corr_q[1] <= tppa_pkg::sat_corr(buf_q.sample_v2, off_q[1]);
      corr_q[2] <= tppa_pkg::sat_corr(buf_q.sample_v3, off_q[2]);
      corr_q[3] <= tppa_pkg::sat_corr(buf_q.sample_i1, off_q[3]);
      corr_q[4] <= tppa_pkg::sat_corr(buf_q.sample_i2, off_q[4]);
      corr_q[5] <= tppa_pkg::sat_corr(buf_q.sample_i3, off_q[5]);
      end_q     <= buf_q.end_window;
    end else if (a_fire) begin
      if (step_q < tppa_pkg::Q_SQ_BASE) begin
        for (int k = 0; k < tppa_pkg::N_CHAN - 1; k++) begin
          raw_q[k] <= raw_q[k+1];
        end
        raw_q[tppa_pkg::N_CHAN-1] <= raw_q[0];
      end else begin
        for (int k = 0; k < tppa_pkg::N_CHAN - 1; k++) begin
          corr_q[k] <= corr_q[k+1];
        end
        corr_q[tppa_pkg::N_CHAN-1] <= corr_q[0];
      end
    end
  end

  // Form this step's addend: raw sample, square or phase product
  always_comb begin
    mul_b = (step_q < tppa_pkg::Q_PWR_BASE) ? corr_q[0] : corr_q[tppa_pkg::N_PHASE];
    prod  = tppa_pkg::PROD_W'(corr_q[0]) * tppa_pkg::PROD_W'(mul_b);
    if (step_q < tppa_pkg::Q_SQ_BASE) begin
      term_d = tppa_pkg::SUM_W'(raw_q[0]);
    end else begin
      term_d = tppa_pkg::SUM_W'(prod);
    end
  end

  // Register the addend beside the memory read
  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_idx_q <= step_q;
      b_end_q <= end_q;
      term_q  <= term_d;
    end
  end

  // Sums are visited in a fixed order, so a write never meets a read of the
  // same entry: no forwarding path is needed.
  tppa_sum_ram u_sum_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (a_fire),
    .rd_addr_i (tppa_pkg::ADDR_W'(step_q)),
    .rd_data_o (rd_data),
    .wr_en_i   (b_fire),
    .wr_addr_i (tppa_pkg::ADDR_W'(b_idx_q)),
    .wr_data_i (b_end_q ? tppa_pkg::sum_t'(0) : sum_new)
  );

  // Add and wrap raw sums to their narrower width
  always_comb begin
    sum_full = rd_data + term_q;
    raw_sum  = sum_full[tppa_pkg::RAW_SUM_W-1:0];
    if (b_idx_q < tppa_pkg::Q_SQ_BASE) begin
      sum_new = tppa_pkg::SUM_W'(raw_sum);
    end else begin
      sum_new = sum_full;
    end
  end

  // Output slot
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.quantity    <= b_idx_q;
      out_q.total       <= sum_new;
      out_q.last_of_run <= (b_idx_q == tppa_pkg::Q_LAST);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

/* hdl/tppa_checker.sv */
`timescale 1ns / 1ps

module tppa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tppa_pkg::out_res_t out_res_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  // Last flag marks exactly the final quantity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.last_of_run == (out_res_o.quantity == tppa_pkg::Q_LAST))
    else $error("last flag does not match quantity");

  // Quantity stays within the sum map
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.quantity <= tppa_pkg::Q_LAST)
    else $error("quantity out of range");

  // Raw sums are sign extended from their narrow width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.quantity < tppa_pkg::Q_SQ_BASE
    |-> out_res_o.total[tppa_pkg::SUM_W-1:tppa_pkg::RAW_SUM_W-1] == '0 ||
        out_res_o.total[tppa_pkg::SUM_W-1:tppa_pkg::RAW_SUM_W-1] == '1)
    else $error("raw sum not sign extended");

endmodule

bind three_phase_power_accumulator tppa_checker u_tppa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned FULL_SETS     = 10;
  localparam tppa_pkg::sample_t SMAX    = 16'sh7fff;
  localparam tppa_pkg::sample_t SMIN    = 16'sh8000;
  localparam tppa_pkg::sample_t SZERO   = 16'sh0000;
  localparam longint      CORR_HI       = (longint'(1) <<< (tppa_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint      CORR_LO       = -CORR_HI - 1;
  // Spare register indexes, writes there must be ignored
  localparam logic [tppa_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [tppa_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_ready_o;
  tppa_pkg::in_req_t                in_req_i    = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  tppa_pkg::out_res_t               out_res_o;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [tppa_pkg::CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [tppa_pkg::SAMPLE_BITS-1:0] cfg_data_i  = '0;

  // Sample sets waiting to be offered, sums waiting to come out
  tppa_pkg::in_req_t  pending[$];
  tppa_pkg::out_res_t sums_due[$];

  // Shadow of the offsets and the running sums
  tppa_pkg::sample_t              offset_q [tppa_pkg::N_CHAN];
  logic [tppa_pkg::RAW_SUM_W-1:0] raw_acc  [tppa_pkg::N_CHAN];
  logic [tppa_pkg::SUM_W-1:0]     sq_acc   [tppa_pkg::N_CHAN];
  logic [tppa_pkg::SUM_W-1:0]     pwr_acc  [tppa_pkg::N_PHASE];

  logic        in_took   = 1'b0;
  logic        idle_en   = 1'b1;
  logic        hold_go   = 1'b0;
  logic        long_hold = 1'b0;
  int unsigned in_gap    = 0;
  int unsigned out_gap   = 0;
  int unsigned bad_sums  = 0;
  int unsigned cycles    = 0;

  three_phase_power_accumulator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Add one sample set to the shadow sums; on a window end queue the readout
  task automatic accumulate_set(input tppa_pkg::in_req_t s);
    tppa_pkg::sample_t  raw  [tppa_pkg::N_CHAN];
    longint             corr [tppa_pkg::N_CHAN];
    tppa_pkg::out_res_t r;
    raw = '{s.sample_v1, s.sample_v2, s.sample_v3, s.sample_i1, s.sample_i2, s.sample_i3};
    for (int k = 0; k < tppa_pkg::N_CHAN; k++) begin
      raw_acc[k] = raw_acc[k] + tppa_pkg::RAW_SUM_W'(raw[k]);
      corr[k] = longint'(raw[k]) - longint'(offset_q[k]);
      if (corr[k] > CORR_HI) begin
        corr[k] = CORR_HI;
      end else if (corr[k] < CORR_LO) begin
        corr[k] = CORR_LO;
      end
      sq_acc[k] = sq_acc[k] + tppa_pkg::SUM_W'(corr[k] * corr[k]);
    end
    for (int p = 0; p < tppa_pkg::N_PHASE; p++) begin
      pwr_acc[p] = pwr_acc[p] + tppa_pkg::SUM_W'(corr[p] * corr[p + tppa_pkg::N_PHASE]);
    end
    if (s.end_window) begin
      for (int q = 0; q < tppa_pkg::NUM_SUMS; q++) begin
        r.quantity = tppa_pkg::QTY_W'(q);
        if (r.quantity < tppa_pkg::Q_SQ_BASE) begin
          r.total = tppa_pkg::SUM_W'($signed(raw_acc[q]));
        end else if (r.quantity < tppa_pkg::Q_PWR_BASE) begin
          r.total = sq_acc[q - tppa_pkg::N_CHAN];
        end else begin
          r.total = pwr_acc[q - 2 * tppa_pkg::N_CHAN];
        end
        r.last_of_run = (r.quantity == tppa_pkg::Q_LAST);
        sums_due.push_back(r);
      end
      for (int k = 0; k < tppa_pkg::N_CHAN; k++) begin
        raw_acc[k] = '0;
        sq_acc[k]  = '0;
      end
      for (int p = 0; p < tppa_pkg::N_PHASE; p++) begin
        pwr_acc[p] = '0;
      end
    end
  endtask

  task automatic log_bad(input string why, input tppa_pkg::out_res_t want,
                         input tppa_pkg::out_res_t got);
    bad_sums++;
    if (bad_sums <= 10) begin
      $display("%0t %s: expected q=%0d total=%0d last=%0b, got q=%0d total=%0d last=%0b",
               $realtime, why, want.quantity, $signed(want.total), want.last_of_run,
               got.quantity, $signed(got.total), got.last_of_run);
    end
  endtask

  // Track register writes and requests, check every sum that leaves
  always @(posedge clk_i) begin : check_p
    tppa_pkg::out_res_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < tppa_pkg::N_CHAN) begin
        offset_q[cfg_index_i] = tppa_pkg::sample_t'(cfg_data_i);
      end
      if (in_valid_i && in_ready_o) begin
        accumulate_set(in_req_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (sums_due.size() == 0) begin
          log_bad("unexpected sum", '0, out_res_o);
        end else begin
          want = sums_due.pop_front();
          if (out_res_o.quantity != want.quantity || out_res_o.total != want.total ||
              out_res_o.last_of_run != want.last_of_run) begin
            log_bad("sum mismatch", want, out_res_o);
          end
        end
      end
    end
    in_took <= rst_ni && in_valid_i && in_ready_o;
  end

  // Offer requests from the queue, with idle bursts when enabled
  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (idle_en && pending.size() > 0 && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 5);
        in_valid_i <= 1'b0;
      end else if (pending.size() > 0) begin
        in_req_i   <= pending.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drop ready in random bursts, and for the whole long hold-off
  always @(negedge clk_i) begin : ready_p
    logic rdy;
    rdy = 1'b1;
    if (out_gap > 0) begin
      out_gap--;
      rdy = 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 5);
      rdy = 1'b0;
    end
    out_ready_i <= rdy && !long_hold;
  end

  // Long receiver hold-off, counted here once the sequence asks for it
  initial begin
    while (!hold_go) @(negedge clk_i);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    long_hold <= 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic tppa_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return SMIN;
      1: return SMAX;
      2: return tppa_pkg::sample_t'(int'($urandom_range(0, 200)) - 100);
      default: return tppa_pkg::sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic tppa_pkg::sample_t pick_offset();
    case ($urandom_range(0, 5))
      0: return SMIN;
      1: return SMAX;
      2: return SZERO;
      3: return tppa_pkg::sample_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return tppa_pkg::sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic tppa_pkg::in_req_t make_set(
      input tppa_pkg::sample_t v1, input tppa_pkg::sample_t v2, input tppa_pkg::sample_t v3,
      input tppa_pkg::sample_t i1, input tppa_pkg::sample_t i2, input tppa_pkg::sample_t i3,
      input logic last);
    tppa_pkg::in_req_t s;
    s.sample_v1  = v1;
    s.sample_v2  = v2;
    s.sample_v3  = v3;
    s.sample_i1  = i1;
    s.sample_i2  = i2;
    s.sample_i3  = i3;
    s.end_window = last;
    return s;
  endfunction

  function automatic tppa_pkg::in_req_t random_set(input logic last);
    return make_set(pick_sample(), pick_sample(), pick_sample(),
                    pick_sample(), pick_sample(), pick_sample(), last);
  endfunction

  // Queue windows of random length, each closed by a window end
  task automatic queue_windows(input int n_items);
    int left;
    int len;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) pending.push_back(random_set(k == len - 1));
      left -= len;
    end
  endtask

  task automatic write_reg(input logic [tppa_pkg::CFG_IDX_W-1:0] idx,
                           input tppa_pkg::sample_t val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_offsets(
      input tppa_pkg::sample_t v1, input tppa_pkg::sample_t v2, input tppa_pkg::sample_t v3,
      input tppa_pkg::sample_t i1, input tppa_pkg::sample_t i2, input tppa_pkg::sample_t i3);
    write_reg(tppa_pkg::REG_OFFSET_V1, v1);
    write_reg(tppa_pkg::REG_OFFSET_V2, v2);
    write_reg(tppa_pkg::REG_OFFSET_V3, v3);
    write_reg(tppa_pkg::REG_OFFSET_I1, i1);
    write_reg(tppa_pkg::REG_OFFSET_I2, i2);
    write_reg(tppa_pkg::REG_OFFSET_I3, i3);
  endtask

  // Wait until every request is taken and every sum is back, then let the block settle
  task automatic drain();
    do @(posedge clk_i); while (pending.size() != 0 || in_valid_i || sums_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    for (int k = 0; k < tppa_pkg::N_CHAN; k++) begin
      offset_q[k] = '0;
      raw_acc[k]  = '0;
      sq_acc[k]   = '0;
    end
    for (int p = 0; p < tppa_pkg::N_PHASE; p++) pwr_acc[p] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset offsets: field extremes, zero, mixed signs
    @(posedge clk_i);
    pending.push_back(make_set(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 1'b0));
    pending.push_back(make_set(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 1'b1));
    pending.push_back(make_set(SZERO, SZERO, SZERO, SZERO, SZERO, SZERO, 1'b1));
    pending.push_back(make_set(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, 1'b0));
    pending.push_back(make_set(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, 1'b1));
    drain();

    // Extreme offsets, plus writes to spare indexes that must not land
    write_offsets(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN);
    write_reg(CFG_SPARE_LO, SMAX);
    write_reg(CFG_SPARE_HI, SMIN);
    @(posedge clk_i);
    pending.push_back(make_set(SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, 1'b0));
    pending.push_back(make_set(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, 1'b0));
    pending.push_back(random_set(1'b1));
    drain();

    // Opposite extremes: clamp the other way, zero samples against full offsets
    write_offsets(SMIN, SMAX, SMIN, SMAX, SMIN, SMAX);
    @(posedge clk_i);
    pending.push_back(make_set(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, 1'b1));
    pending.push_back(make_set(SZERO, SZERO, SZERO, SZERO, SZERO, SZERO, 1'b1));
    drain();

    // Hold off the receiver while several window ends pile up
    write_offsets(pick_offset(), pick_offset(), pick_offset(),
                  pick_offset(), pick_offset(), pick_offset());
    @(posedge clk_i);
    hold_go <= 1'b1;
    for (int k = 0; k < 16; k++) begin
      pending.push_back(random_set(k == 1 || k == 4 || k == 8 || k == 15));
    end
    drain();

    // Random windows under several offset settings
    repeat (3) begin
      write_offsets(pick_offset(), pick_offset(), pick_offset(),
                    pick_offset(), pick_offset(), pick_offset());
      @(posedge clk_i);
      queue_windows(45);
      drain();
    end

    // One window at full scale, voltages and currents at opposite extremes
    @(posedge clk_i);
    for (int k = 0; k < FULL_SETS; k++) begin
      pending.push_back(make_set(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, k == FULL_SETS - 1));
    end
    drain();

    // Closing stretch without idling
    write_offsets(pick_offset(), pick_offset(), pick_offset(),
                  pick_offset(), pick_offset(), pick_offset());
    @(posedge clk_i);
    idle_en <= 1'b0;
    queue_windows(40);
    drain();

    if (bad_sums == 0 && sums_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
